// File: design/tvp_pkg.sv
// shared types, constants and saturation helpers of the two-axis velocity pid
package tvp_pkg;

	localparam int unsigned SETPOINT_TAU_DEF = 3277;
	localparam logic [30:0] DT_MIN = 31'd66;
	localparam int CFG_IDX_W = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KP_X    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_X    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_X    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_Y    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_Y    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_Y    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y = 4'd7;

	typedef struct packed {
		logic signed [31:0] cmd_vx;
		logic signed [31:0] cmd_vy;
		logic signed [31:0] cmd_vz;
		logic signed [31:0] cmd_yaw_rate;
		logic signed [31:0] meas_vx;
		logic signed [31:0] meas_vy;
		logic        [30:0] elapsed;
	} tvp_in_t;

	typedef struct packed {
		logic signed [31:0] pitch_out;
		logic signed [31:0] roll_out;
		logic signed [31:0] vz_out;
		logic signed [31:0] yaw_rate_out;
	} tvp_out_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FR_LD, ST_FR_RUN, ST_FR_WB,
		ST_FC_M1_LD, ST_FC_M1_RUN, ST_FC_M2_LD, ST_FC_M2_RUN,
		ST_FC_D_LD, ST_FC_D_RUN, ST_FC_WB,
		ST_AC_LD, ST_AC_RUN, ST_AC_WB,
		ST_IG_LD, ST_IG_RUN, ST_IG_WB,
		ST_KP_LD, ST_KP_RUN, ST_KD_LD, ST_KD_RUN, ST_KI_LD, ST_KI_RUN,
		ST_PO_WB, ST_DONE
	} tvp_state_t;

	typedef enum logic [2:0] {
		MS_DT_CMD, MS_TC_FC, MS_DT_PERR, MS_KP, MS_KD, MS_KI
	} tvp_mul_sel_t;

	typedef enum logic [1:0] {
		DS_FR, DS_FC, DS_AC
	} tvp_div_sel_t;

	typedef struct packed {
		logic         in_ready;
		logic         mul_ld;
		logic         mul_run;
		tvp_mul_sel_t mul_sel;
		logic         acc_clr;
		logic         div_ld;
		logic         div_run;
		tvp_div_sel_t div_sel;
		logic         wb_fr;
		logic         wb_fc;
		logic         wb_ac;
		logic         wb_ig;
		logic         wb_po;
		logic         done;
	} tvp_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		else if (v < -66'sh80000000)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v[48] != v[47])
			return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		else
			return v[47:0];
	endfunction

endpackage

// File: design/tvp_in_if.sv
// input word channel carrying one set of commanded and measured velocities
interface tvp_in_if;
	logic             valid;
	logic             ready;
	tvp_pkg::tvp_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/tvp_out_if.sv
// output word channel carrying pitch, roll, vertical speed and yaw rate
interface tvp_out_if;
	logic              valid;
	logic              ready;
	tvp_pkg::tvp_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/tvp_cfg_if.sv
// register write channel with index and write data
interface tvp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tvp_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: design/two_axis_velocity_pid.sv
// two-axis velocity pid with filtered setpoint, bit-serial datapath
//
// usage: in_ch takes one word of commanded x/y/z velocity, yaw rate, measured
// x/y velocity and elapsed time (all q16.16). out_ch returns one word of
// pitch, roll, vertical speed and yaw rate for every input word. cfg_ch
// writes gains and limits by index; it is always ready. the user is to write
// it only while the block is idle; the block itself does not enforce this.
// out-of-range indexes are dropped. the first word after reset only records
// the measured velocities and answers with zeros through the output register.
// later words run both axes one after the other through one shared
// shift-add multiplier (one multiplier bit per cycle) and one restoring
// divider (one quotient bit per cycle, 64 steps). the multiply by the filter
// constant uses TC_W multiplier bits (TC_W = clog2(SETPOINT_TAU+1)+1, 13 by
// default), every other multiply uses 32.
// one word is in flight at a time; in_ch.ready is high only when idle.
// the result sits in an output register; if out_ch stalls, the block holds
// the finished word and waits before returning to idle.
// reset clears gains, limits, filter and integrator state and the
// started flag, and drops any pending output.
module two_axis_velocity_pid #(
	parameter int unsigned SETPOINT_TAU = tvp_pkg::SETPOINT_TAU_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tvp_in_if.sink    in_ch,
	tvp_out_if.source out_ch,
	tvp_cfg_if.sink   cfg_ch
);
	import tvp_pkg::*;

	// bits of the constant's serial multiplier word, sign bit included
	localparam int TC_W = $clog2(SETPOINT_TAU + 1) + 1;

	tvp_state_t state_q, state_nxt;
	tvp_ctl_t   ctl;

	// configuration registers, indexed by axis
	logic signed [31:0] kp_q [2];
	logic signed [31:0] ki_q [2];
	logic signed [31:0] kd_q [2];
	logic        [30:0] lim_q [2];

	// per-axis controller state
	logic signed [31:0] fc_q [2];
	logic signed [31:0] fr_q [2];
	logic signed [47:0] ig_q [2];
	logic signed [31:0] prev_q [2];
	logic signed [31:0] res_q [2];
	logic               started_q;

	// latched input word
	logic signed [31:0] cmd_q [2];
	logic signed [31:0] meas_q [2];
	logic signed [31:0] vz_q;
	logic signed [31:0] yaw_q;
	logic        [30:0] dt_q;
	logic               axis_q;

	// shared serial units
	logic signed [81:0] acc_q;
	logic signed [81:0] mcand_q;
	logic        [31:0] mplr_q;
	logic        [5:0]  cnt_q;
	logic        [5:0]  last_q;
	logic        [63:0] dq_q;
	logic        [31:0] rem_q;
	logic        [31:0] dd_q;
	logic               dneg_q;
	logic signed [31:0] accel_q;

	tvp_out_t out_q;
	logic     out_valid_q;

	// axis operands
	logic signed [31:0] cmd_raw, cmd_l, fc_cur, meas_cur;
	logic signed [32:0] cmd33, lim33, perr, derr, fr_diff, ac_diff;
	logic        [30:0] lim_cur;
	logic        [31:0] den;
	logic               run_end;

	assign cmd_raw  = cmd_q[axis_q];
	assign lim_cur  = lim_q[axis_q];
	assign fc_cur   = fc_q[axis_q];
	assign meas_cur = meas_q[axis_q];
	assign cmd33    = {cmd_raw[31], cmd_raw};
	assign lim33    = {2'b00, lim_cur};

	// command limiting, zero limit disables it
	always_comb begin
		cmd_l = cmd_raw;
		if (lim_cur != '0) begin
			if (cmd33 > lim33)
				cmd_l = lim33[31:0];
			else if (cmd33 < -lim33)
				cmd_l = 32'(-lim33);
		end
	end

	assign fr_diff = {cmd_l[31], cmd_l} - {fc_cur[31], fc_cur};
	assign ac_diff = {meas_cur[31], meas_cur} - {prev_q[axis_q][31], prev_q[axis_q]};
	assign perr    = {fc_cur[31], fc_cur} - {meas_cur[31], meas_cur};
	assign derr    = {fr_q[axis_q][31], fr_q[axis_q]} - {accel_q[31], accel_q};
	assign den     = {1'b0, dt_q} + 32'(SETPOINT_TAU);
	assign run_end = (cnt_q == last_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid)
					state_nxt = started_q ? ST_FR_LD : ST_DONE;
			end
			ST_FR_LD:     state_nxt = ST_FR_RUN;
			ST_FR_RUN:    if (run_end) state_nxt = ST_FR_WB;
			ST_FR_WB:     state_nxt = ST_FC_M1_LD;
			ST_FC_M1_LD:  state_nxt = ST_FC_M1_RUN;
			ST_FC_M1_RUN: if (run_end) state_nxt = ST_FC_M2_LD;
			ST_FC_M2_LD:  state_nxt = ST_FC_M2_RUN;
			ST_FC_M2_RUN: if (run_end) state_nxt = ST_FC_D_LD;
			ST_FC_D_LD:   state_nxt = ST_FC_D_RUN;
			ST_FC_D_RUN:  if (run_end) state_nxt = ST_FC_WB;
			ST_FC_WB:     state_nxt = ST_AC_LD;
			ST_AC_LD:     state_nxt = ST_AC_RUN;
			ST_AC_RUN:    if (run_end) state_nxt = ST_AC_WB;
			ST_AC_WB:     state_nxt = ST_IG_LD;
			ST_IG_LD:     state_nxt = ST_IG_RUN;
			ST_IG_RUN:    if (run_end) state_nxt = ST_IG_WB;
			ST_IG_WB:     state_nxt = ST_KP_LD;
			ST_KP_LD:     state_nxt = ST_KP_RUN;
			ST_KP_RUN:    if (run_end) state_nxt = ST_KD_LD;
			ST_KD_LD:     state_nxt = ST_KD_RUN;
			ST_KD_RUN:    if (run_end) state_nxt = ST_KI_LD;
			ST_KI_LD:     state_nxt = ST_KI_RUN;
			ST_KI_RUN:    if (run_end) state_nxt = ST_PO_WB;
			ST_PO_WB:     state_nxt = axis_q ? ST_DONE : ST_FR_LD;
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready)
					state_nxt = ST_IDLE;
			end
			default:      state_nxt = ST_IDLE;
		endcase
	end

	// control decode
	always_comb begin
		ctl = '0;
		ctl.mul_sel = MS_DT_CMD;
		ctl.div_sel = DS_FR;
		case (state_q)
			ST_IDLE:      ctl.in_ready = 1'b1;
			ST_FR_LD: begin
				ctl.div_ld  = 1'b1;
				ctl.div_sel = DS_FR;
			end
			ST_FC_D_LD: begin
				ctl.div_ld  = 1'b1;
				ctl.div_sel = DS_FC;
			end
			ST_AC_LD: begin
				ctl.div_ld  = 1'b1;
				ctl.div_sel = DS_AC;
			end
			ST_FR_RUN, ST_FC_D_RUN, ST_AC_RUN: ctl.div_run = 1'b1;
			ST_FR_WB:     ctl.wb_fr = 1'b1;
			ST_FC_WB:     ctl.wb_fc = 1'b1;
			ST_AC_WB:     ctl.wb_ac = 1'b1;
			ST_IG_WB:     ctl.wb_ig = 1'b1;
			ST_PO_WB:     ctl.wb_po = 1'b1;
			ST_FC_M1_LD: begin
				ctl.mul_ld  = 1'b1;
				ctl.acc_clr = 1'b1;
				ctl.mul_sel = MS_DT_CMD;
			end
			ST_FC_M2_LD: begin
				ctl.mul_ld  = 1'b1;
				ctl.mul_sel = MS_TC_FC;
			end
			ST_IG_LD: begin
				ctl.mul_ld  = 1'b1;
				ctl.acc_clr = 1'b1;
				ctl.mul_sel = MS_DT_PERR;
			end
			ST_KP_LD: begin
				ctl.mul_ld  = 1'b1;
				ctl.acc_clr = 1'b1;
				ctl.mul_sel = MS_KP;
			end
			ST_KD_LD: begin
				ctl.mul_ld  = 1'b1;
				ctl.mul_sel = MS_KD;
			end
			ST_KI_LD: begin
				ctl.mul_ld  = 1'b1;
				ctl.mul_sel = MS_KI;
			end
			ST_FC_M1_RUN, ST_FC_M2_RUN, ST_IG_RUN, ST_KP_RUN, ST_KD_RUN, ST_KI_RUN:
				ctl.mul_run = 1'b1;
			ST_DONE:      ctl.done = !out_valid_q || out_ch.ready;
			default:      ctl = '0;
		endcase
	end

	assign in_ch.ready  = ctl.in_ready;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				kp_q[i]  <= '0;
				ki_q[i]  <= '0;
				kd_q[i]  <= '0;
				lim_q[i] <= '0;
			end
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_KP_X:    kp_q[0]  <= cfg_ch.wdata;
				REG_KI_X:    ki_q[0]  <= cfg_ch.wdata;
				REG_KD_X:    kd_q[0]  <= cfg_ch.wdata;
				REG_KP_Y:    kp_q[1]  <= cfg_ch.wdata;
				REG_KI_Y:    ki_q[1]  <= cfg_ch.wdata;
				REG_KD_Y:    kd_q[1]  <= cfg_ch.wdata;
				REG_LIMIT_X: lim_q[0] <= cfg_ch.wdata[30:0];
				REG_LIMIT_Y: lim_q[1] <= cfg_ch.wdata[30:0];
				default:     ;
			endcase
		end
	end

	// input latch, first-word handling, axis sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			axis_q    <= 1'b0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else begin
			if (ctl.in_ready && in_ch.valid) begin
				axis_q <= 1'b0;
				if (!started_q) begin
					// first word only records the measured velocities
					started_q <= 1'b1;
					prev_q[0] <= in_ch.data.meas_vx;
					prev_q[1] <= in_ch.data.meas_vy;
				end
			end
			if (ctl.wb_po) begin
				axis_q <= 1'b1;
				if (axis_q) begin
					prev_q[0] <= meas_q[0];
					prev_q[1] <= meas_q[1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_ready && in_ch.valid) begin
			cmd_q[0]  <= in_ch.data.cmd_vx;
			cmd_q[1]  <= in_ch.data.cmd_vy;
			meas_q[0] <= in_ch.data.meas_vx;
			meas_q[1] <= in_ch.data.meas_vy;
			dt_q      <= (in_ch.data.elapsed < DT_MIN) ? DT_MIN : in_ch.data.elapsed;
			vz_q      <= started_q ? in_ch.data.cmd_vz : '0;
			yaw_q     <= started_q ? in_ch.data.cmd_yaw_rate : '0;
			if (!started_q) begin
				res_q[0] <= '0;
				res_q[1] <= '0;
			end
		end
		if (ctl.wb_po)
			res_q[axis_q] <= sat32(acc_q[81:16]);
	end

	// shift-add multiplier, one multiplier bit per cycle, accumulates into acc_q
	always_ff @(posedge clk) begin
		if (ctl.mul_ld) begin
			if (ctl.acc_clr)
				acc_q <= '0;
			case (ctl.mul_sel)
				MS_DT_CMD: begin
					mcand_q <= 82'(cmd_l);
					mplr_q  <= {1'b0, dt_q};
				end
				MS_TC_FC: begin
					mcand_q <= 82'(fc_cur);
					mplr_q  <= 32'(SETPOINT_TAU);
				end
				MS_DT_PERR: begin
					mcand_q <= 82'(perr);
					mplr_q  <= {1'b0, dt_q};
				end
				MS_KP: begin
					mcand_q <= 82'(perr);
					mplr_q  <= kp_q[axis_q];
				end
				MS_KD: begin
					mcand_q <= 82'(derr);
					mplr_q  <= kd_q[axis_q];
				end
				MS_KI: begin
					mcand_q <= 82'(ig_q[axis_q]);
					mplr_q  <= ki_q[axis_q];
				end
				default: begin
					mcand_q <= '0;
					mplr_q  <= '0;
				end
			endcase
		end else if (ctl.div_ld && ctl.div_sel == DS_FR) begin
			acc_q <= '0;
		end else if (ctl.mul_run) begin
			// top multiplier bit carries negative weight
			if (mplr_q[0])
				acc_q <= run_end ? acc_q - mcand_q : acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplr_q  <= mplr_q >> 1;
		end
	end

	// shared step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else if (ctl.mul_ld) begin
			cnt_q  <= '0;
			last_q <= (ctl.mul_sel == MS_TC_FC) ? 6'(TC_W - 1) : 6'd31;
		end else if (ctl.div_ld) begin
			cnt_q  <= '0;
			last_q <= 6'd63;
		end else if (ctl.mul_run || ctl.div_run) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	// restoring divider, one quotient bit per cycle on magnitudes
	logic signed [81:0] div_num;
	logic signed [81:0] div_mag;
	logic        [32:0] div_trial;
	logic               div_ge;
	logic signed [64:0] quot;

	always_comb begin
		case (ctl.div_sel)
			DS_FR:   div_num = {{33{fr_diff[32]}}, fr_diff, 16'b0};
			DS_AC:   div_num = {{33{ac_diff[32]}}, ac_diff, 16'b0};
			DS_FC:   div_num = acc_q;
			default: div_num = acc_q;
		endcase
	end

	assign div_mag   = div_num[81] ? -div_num : div_num;
	assign div_trial = {rem_q, dq_q[63]};
	assign div_ge    = div_trial >= {1'b0, dd_q};
	assign quot      = dneg_q ? -{1'b0, dq_q} : {1'b0, dq_q};

	always_ff @(posedge clk) begin
		if (ctl.div_ld) begin
			dq_q   <= div_mag[63:0];
			rem_q  <= '0;
			dneg_q <= div_num[81];
			dd_q   <= (ctl.div_sel == DS_AC) ? {1'b0, dt_q} : den;
		end else if (ctl.div_run) begin
			rem_q <= div_ge ? 32'(div_trial - {1'b0, dd_q}) : div_trial[31:0];
			dq_q  <= {dq_q[62:0], div_ge};
		end
		if (ctl.wb_ac)
			accel_q <= sat32({quot[64], quot});
	end

	// integrator update: dt*perr truncated toward zero by 2^16, saturated to 48 bits
	logic signed [63:0] ig_prod;
	logic signed [63:0] ig_biased;
	logic signed [48:0] ig_sum;

	assign ig_prod   = acc_q[63:0];
	assign ig_biased = ig_prod + (ig_prod[63] ? 64'sd65535 : 64'sd0);
	assign ig_sum    = {ig_q[axis_q][47], ig_q[axis_q]} +
	                   {ig_biased[63], ig_biased[63:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				fc_q[i] <= '0;
				fr_q[i] <= '0;
				ig_q[i] <= '0;
			end
		end else begin
			if (ctl.wb_fr)
				fr_q[axis_q] <= sat32({quot[64], quot});
			if (ctl.wb_fc)
				fc_q[axis_q] <= quot[31:0];
			if (ctl.wb_ig)
				ig_q[axis_q] <= sat48(ig_sum);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.done)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			out_q.pitch_out    <= res_q[0];
			out_q.roll_out     <= res_q[1];
			out_q.vz_out       <= vz_q;
			out_q.yaw_rate_out <= yaw_q;
		end
	end

endmodule

// File: design/tvp_checker.sv
// port-level checks of the two-axis velocity pid and their binding
module tvp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input tvp_pkg::tvp_out_t out_data
);
	import tvp_pkg::*;

	// a held output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output word changed while stalled");

	// one word in flight: input closes right after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second input word taken while busy");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind two_axis_velocity_pid tvp_checker u_tvp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
